// ===== rtl/core/ftmc_pkg.sv =====
// ftmc_pkg: types and constants shared by the five-tuple classifier files.
// No dependencies.
package ftmc_pkg;

   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;
   localparam int PRIO_W  = 10;

   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [31:0]         src_lo;
      logic [31:0]         src_hi;
      logic [31:0]         dst_lo;
      logic [31:0]         dst_hi;
      logic [15:0]         sport_lo;
      logic [15:0]         sport_hi;
      logic [15:0]         dport_lo;
      logic [15:0]         dport_hi;
      logic [7:0]          proto_lo;
      logic [7:0]          proto_hi;
   } req_type;

   typedef struct packed {
      logic                matched;
      logic [PRIO_W-1:0]   priority_res;
   } rsp_type;

   typedef struct packed {
      logic [31:0] src_lo;
      logic [31:0] src_hi;
      logic [31:0] dst_lo;
      logic [31:0] dst_hi;
      logic [15:0] sport_lo;
      logic [15:0] sport_hi;
      logic [15:0] dport_lo;
      logic [15:0] dport_hi;
      logic [7:0]  proto_lo;
      logic [7:0]  proto_hi;
   } rule_type;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
   } key_type;

endpackage

// ===== rtl/core/ftmc_req_if.sv =====
// ftmc_req_if: request channel (valid/ready plus request item).
// Depends on ftmc_pkg.
interface ftmc_req_if;
   logic             valid;
   logic             ready;
   ftmc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ftmc_rsp_if.sv =====
// ftmc_rsp_if: response channel (valid/ready plus result item).
// Depends on ftmc_pkg.
interface ftmc_rsp_if;
   logic             valid;
   logic             ready;
   ftmc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ftmc_rule_match.sv =====
// ftmc_rule_match: checks one stored rule against a packet key, all five ranges.
// Depends on ftmc_pkg.
module ftmc_rule_match (
   input  ftmc_pkg::rule_type rule,
   input  ftmc_pkg::key_type  key,
   output logic               hit
);
   import ftmc_pkg::*;

   logic src_ok, dst_ok, sport_ok, dport_ok, proto_ok;

   assign src_ok   = (key.src   >= rule.src_lo)   && (key.src   <= rule.src_hi);
   assign dst_ok   = (key.dst   >= rule.dst_lo)   && (key.dst   <= rule.dst_hi);
   assign sport_ok = (key.sport >= rule.sport_lo) && (key.sport <= rule.sport_hi);
   assign dport_ok = (key.dport >= rule.dport_lo) && (key.dport <= rule.dport_hi);
   assign proto_ok = (key.proto >= rule.proto_lo) && (key.proto <= rule.proto_hi);

   assign hit = src_ok && dst_ok && sport_ok && dport_ok && proto_ok;

endmodule

// ===== rtl/core/five_tuple_first_match_classifier_top.sv =====
// five_tuple_first_match_classifier_top: first-match five-tuple classifier, rule memory
// plus scan sequencer. Depends on ftmc_pkg, ftmc_req_if, ftmc_rsp_if, ftmc_rule_match.
//
// Rules live in one single-port-style memory of MAX_RULES entries, one rule per entry.
// A write item stores its rule and yields no result. A lookup item reads rules from
// slot 0 upward, one per cycle, and stops at the first hit or after n rules, n being
// rule_count capped at MAX_RULES. Each rule is registered, then compared with the key.
// The one-rule-per-cycle memory read sets that rate. New items are taken only while no
// lookup is in progress; a finished result sits in an output register, so the next item
// may enter while it waits to be taken.
// Slots never written read as undefined; scan only written slots.
module five_tuple_first_match_classifier_top #(
   parameter int MAX_RULES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   ftmc_req_if.sink                      req_ch,
   ftmc_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [ftmc_pkg::COUNT_W-1:0]  csr_wr_data
);
   import ftmc_pkg::*;

   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CNT_W = $clog2(MAX_RULES + 1);

   logic [COUNT_W-1:0] rule_count_ff;
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [CNT_W-1:0]   cmp_idx_ff;
   logic               cmp_vld_ff;
   key_type            key_ff;
   rule_type           mem [MAX_RULES];
   rule_type           rdata_ff;
   rule_type           wr_rule;
   rsp_type            result_ff, result_in;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   logic               req_fire, rsp_free, rsp_load;
   logic               mem_we, mem_re, rule_hit, hit;
   logic [CNT_W-1:0]   limit_new;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign mem_we = req_fire && (req_ch.payload.op == OP_WRITE) &&
                   (32'(req_ch.payload.slot) < 32'(MAX_RULES));
   assign mem_re = (state_ff == ST_SCAN) && (addr_ff < limit_ff);

   assign limit_new = (32'(rule_count_ff) > 32'(MAX_RULES)) ? CNT_W'(MAX_RULES)
                                                             : CNT_W'(rule_count_ff);

   assign wr_rule = '{src_lo:   req_ch.payload.src_lo,   src_hi:   req_ch.payload.src_hi,
                      dst_lo:   req_ch.payload.dst_lo,   dst_hi:   req_ch.payload.dst_hi,
                      sport_lo: req_ch.payload.sport_lo, sport_hi: req_ch.payload.sport_hi,
                      dport_lo: req_ch.payload.dport_lo, dport_hi: req_ch.payload.dport_hi,
                      proto_lo: req_ch.payload.proto_lo, proto_hi: req_ch.payload.proto_hi};

   ftmc_rule_match u_match (
      .rule (rdata_ff),
      .key  (key_ff),
      .hit  (rule_hit)
   );

   assign hit = cmp_vld_ff && rule_hit;

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      limit_in  = limit_ff;
      result_in = result_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.payload.op == OP_LOOKUP)) begin
               state_in = ST_SCAN;
               addr_in  = '0;
               limit_in = limit_new;
            end
         end
         ST_SCAN: begin
            if (mem_re) begin
               addr_in = addr_ff + 1'b1;
            end
            if (hit) begin
               result_in = '{matched: 1'b1, priority_res: PRIO_W'(cmp_idx_ff)};
               state_in  = ST_FINISH;
            end else if (!cmp_vld_ff && !mem_re) begin
               result_in = '0;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         addr_ff       <= '0;
         limit_ff      <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rule_count_ff <= '0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         limit_ff   <= limit_in;
         cmp_vld_ff <= mem_re;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            rule_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff  <= result_in;
      cmp_idx_ff <= addr_ff;
      if (req_fire && (req_ch.payload.op == OP_LOOKUP)) begin
         key_ff <= '{src:   req_ch.payload.src_lo,   dst:   req_ch.payload.dst_lo,
                     sport: req_ch.payload.sport_lo, dport: req_ch.payload.dport_lo,
                     proto: req_ch.payload.proto_lo};
      end
      if (rsp_load) begin
         rsp_ff <= result_ff;
      end
   end

   // writes happen only in idle, reads only while scanning: no same-entry overlap
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[IDX_W'(req_ch.payload.slot)] <= wr_rule;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[addr_ff[IDX_W-1:0]];
      end
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("rule write and scan read in the same cycle");

   a_scan_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (addr_ff <= limit_ff))
      else $error("scan address past rule count");

   a_hit_below_limit: assert property (@(posedge clock) disable iff (reset)
      hit |-> (cmp_idx_ff < limit_ff))
      else $error("hit reported on slot beyond rule count");

   a_miss_zero_prio: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_ff.matched || (rsp_ff.priority_res == '0)))
      else $error("miss result with nonzero priority");

   a_result_follows_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> ($past(state_ff) == ST_SCAN) || ($past(state_ff) == ST_FINISH))
      else $error("result loaded without a lookup");

endmodule
